// File: design/sipq_pkg.sv
package sipq_pkg;

   // Default sizes
   localparam int DEPTH_DEF       = 16;
   localparam int KEY_WIDTH_DEF   = 32;
   localparam int VALUE_WIDTH_DEF = 32;

   // Fixed port field widths
   localparam int OPCODE_W = 3;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // Opcodes
   localparam logic [OPCODE_W-1:0] OP_APPEND = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_PUSH   = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_SORTED = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_UNIQUE = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_POP    = 3'd4;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DUP   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

   // Where an insert lands
   typedef enum logic [1:0] {
      POS_HEAD   = 2'd0,
      POS_TAIL   = 2'd1,
      POS_SORTED = 2'd2
   } pos_mode_type;

   // Sequencer states
   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_CMP    = 3'b010,
      S_COMMIT = 3'b100
   } state_type;

   // Control broadcast from the sequencer to every cell
   typedef struct packed {
      logic         cmp_en;
      logic         ins_en;
      logic         pop_en;
      pos_mode_type pos_mode;
   } cell_ctrl_type;

endpackage

// File: design/sorted_insert_priority_queue.sv
// Sorted-insert priority queue built as a row of DEPTH entry cells.
// The request passes the compare and commit states; the result is registered at commit,
// which a stalled response holds. A new request is taken only while idle (accept, per-cell
// key compare, commit); the commit step carries the prefix chain across the whole cell row.
// Reset clears the entry count, the sequencer and the response valid; entries are not cleared.
module sorted_insert_priority_queue #(
   parameter int DEPTH       = sipq_pkg::DEPTH_DEF,
   parameter int KEY_WIDTH   = sipq_pkg::KEY_WIDTH_DEF,
   parameter int VALUE_WIDTH = sipq_pkg::VALUE_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [sipq_pkg::OPCODE_W-1:0]     req_opcode,
   input  logic [sipq_pkg::DATA_W-1:0]       req_key,
   input  logic [sipq_pkg::DATA_W-1:0]       req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sipq_pkg::DATA_W-1:0]       rsp_out_key,
   output logic [sipq_pkg::DATA_W-1:0]       rsp_out_value,
   output logic [sipq_pkg::STATUS_W-1:0]     rsp_status,
   output logic [sipq_pkg::COUNT_W-1:0]      rsp_entry_count
);
   import sipq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   state_type state_ff, state_in;

   logic [OPCODE_W-1:0]    op_ff, op_in;
   logic [KEY_WIDTH-1:0]   key_ff, key_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]      rsp_key_ff, rsp_key_in;
   logic [DATA_W-1:0]      rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]     rsp_count_ff, rsp_count_in;

   logic [KEY_WIDTH+DATA_W-1:0]   key_wide;
   logic [VALUE_WIDTH+DATA_W-1:0] value_wide;
   logic [KEY_WIDTH+DATA_W-1:0]   head_key_wide;
   logic [VALUE_WIDTH+DATA_W-1:0] head_value_wide;
   logic [CNT_W+COUNT_W-1:0]      count_wide;

   cell_ctrl_type          ctrl;
   logic                   req_xfer, commit_go, full, empty, dup_any;
   logic                   do_ins, do_pop;
   logic [STATUS_W-1:0]    status;

   logic [KEY_WIDTH-1:0]   cell_key   [DEPTH];
   logic [VALUE_WIDTH-1:0] cell_value [DEPTH];
   logic [DEPTH-1:0]       after_vec, prefix_vec, dup_vec;

   // Handshakes
   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign commit_go = (state_ff == S_COMMIT) && (!rsp_valid_ff || !rsp_stall);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (req_xfer) state_in = S_CMP;
         S_CMP:    state_in = S_COMMIT;
         S_COMMIT: if (commit_go) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // Request capture, keeping only the stored key and value bits
   assign key_wide   = (KEY_WIDTH + DATA_W)'(req_key);
   assign value_wide = (VALUE_WIDTH + DATA_W)'(req_value);
   assign op_in      = req_xfer ? req_opcode : op_ff;
   assign key_in     = req_xfer ? key_wide[KEY_WIDTH-1:0] : key_ff;
   assign value_in   = req_xfer ? value_wide[VALUE_WIDTH-1:0] : value_ff;

   // Decide the operation at commit
   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign dup_any = |dup_vec;

   always_comb begin
      do_ins = 1'b0;
      do_pop = 1'b0;
      status = ST_DONE;
      ctrl.pos_mode = POS_SORTED;
      case (op_ff)
         OP_APPEND, OP_PUSH, OP_SORTED: begin
            ctrl.pos_mode = (op_ff == OP_APPEND) ? POS_TAIL :
                            (op_ff == OP_PUSH)   ? POS_HEAD : POS_SORTED;
            if (full) status = ST_FULL;
            else      do_ins = 1'b1;
         end
         OP_UNIQUE: begin
            if (dup_any)   status = ST_DUP;
            else if (full) status = ST_FULL;
            else           do_ins = 1'b1;
         end
         OP_POP: begin
            if (empty) status = ST_EMPTY;
            else       do_pop = 1'b1;
         end
         default: status = ST_DONE;
      endcase
      ctrl.cmp_en = (state_ff == S_CMP);
      ctrl.ins_en = commit_go && do_ins;
      ctrl.pop_en = commit_go && do_pop;
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.ins_en)      count_in = count_ff + 1'b1;
      else if (ctrl.pop_en) count_in = count_ff - 1'b1;
   end

   // Result register
   assign head_key_wide   = (KEY_WIDTH + DATA_W)'(cell_key[0]);
   assign head_value_wide = (VALUE_WIDTH + DATA_W)'(cell_value[0]);
   assign count_wide      = (CNT_W + COUNT_W)'(count_in);

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (commit_go) begin
         rsp_valid_in  = 1'b1;
         rsp_key_in    = do_pop ? head_key_wide[DATA_W-1:0] : '0;
         rsp_value_in  = do_pop ? head_value_wide[DATA_W-1:0] : '0;
         rsp_status_in = status;
         rsp_count_in  = count_wide[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_key     = rsp_key_ff;
   assign rsp_out_value   = rsp_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

   // Cell row, head at index 0
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [KEY_WIDTH-1:0]   l_key, r_key;
      logic [VALUE_WIDTH-1:0] l_value, r_value;
      logic                   l_after, p_in;

      if (i == 0) begin : g_head
         assign l_key   = key_ff;
         assign l_value = value_ff;
         assign l_after = 1'b0;
         assign p_in    = 1'b1;
      end else begin : g_body
         assign l_key   = cell_key[i-1];
         assign l_value = cell_value[i-1];
         assign l_after = after_vec[i-1];
         assign p_in    = prefix_vec[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign r_key   = cell_key[i];
         assign r_value = cell_value[i];
      end else begin : g_inner
         assign r_key   = cell_key[i+1];
         assign r_value = cell_value[i+1];
      end

      sipq_cell #(
         .KEY_WIDTH   (KEY_WIDTH),
         .VALUE_WIDTH (VALUE_WIDTH),
         .CNT_W       (CNT_W),
         .INDEX       (i)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .new_key     (key_ff),
         .new_value   (value_ff),
         .count       (count_ff),
         .left_key    (l_key),
         .left_value  (l_value),
         .left_after  (l_after),
         .right_key   (r_key),
         .right_value (r_value),
         .prefix_in   (p_in),
         .cell_key    (cell_key[i]),
         .cell_value  (cell_value[i]),
         .after_out   (after_vec[i]),
         .prefix_out  (prefix_vec[i]),
         .dup         (dup_vec[i])
      );
   end

endmodule

// File: design/sipq_cell.sv
module sipq_cell #(
   parameter int KEY_WIDTH   = 32,
   parameter int VALUE_WIDTH = 32,
   parameter int CNT_W       = 5,
   parameter int INDEX       = 0
) (
   input  logic                     clock,
   input  sipq_pkg::cell_ctrl_type  ctrl,
   input  logic [KEY_WIDTH-1:0]     new_key,
   input  logic [VALUE_WIDTH-1:0]   new_value,
   input  logic [CNT_W-1:0]         count,
   input  logic [KEY_WIDTH-1:0]     left_key,
   input  logic [VALUE_WIDTH-1:0]   left_value,
   input  logic                     left_after,
   input  logic [KEY_WIDTH-1:0]     right_key,
   input  logic [VALUE_WIDTH-1:0]   right_value,
   input  logic                     prefix_in,
   output logic [KEY_WIDTH-1:0]     cell_key,
   output logic [VALUE_WIDTH-1:0]   cell_value,
   output logic                     after_out,
   output logic                     prefix_out,
   output logic                     dup
);
   import sipq_pkg::*;

   localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

   logic [KEY_WIDTH-1:0]   key_ff, key_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic                   lt_ff, lt_in;
   logic                   eq_ff, eq_in;
   logic                   valid;

   // Entry is live when it sits below the fill count
   assign valid = (count > IDX);

   // Compare against the pending key
   assign lt_in = ctrl.cmp_en ? (key_ff < new_key)  : lt_ff;
   assign eq_in = ctrl.cmp_en ? (key_ff == new_key) : eq_ff;

   // Prefix of "all entries so far are smaller", rippled tailward
   assign prefix_out = prefix_in && valid && lt_ff;
   assign dup        = prefix_in && valid && eq_ff;

   // Is this cell at or behind the insert position
   always_comb begin
      case (ctrl.pos_mode)
         POS_HEAD:   after_out = 1'b1;
         POS_TAIL:   after_out = !valid;
         POS_SORTED: after_out = !prefix_out;
         default:    after_out = 1'b0;
      endcase
   end

   // Shift tailward on insert, headward on pop
   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      if (ctrl.ins_en && after_out) begin
         key_in   = left_after ? left_key   : new_key;
         value_in = left_after ? left_value : new_value;
      end else if (ctrl.pop_en) begin
         key_in   = right_key;
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      lt_ff    <= lt_in;
      eq_ff    <= eq_in;
   end

   assign cell_key   = key_ff;
   assign cell_value = value_ff;

endmodule
